[hdl/integer_literal_parser_defines.svh]
// Assertion macros for the integer literal parser.
`ifndef INTEGER_LITERAL_PARSER_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define ILP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("integer_literal_parser assertion failed");

`define ILP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer_literal_parser assertion failed");

`else

`define ILP_ASSERT(label, clk, rst, prop)

`define ILP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/ilp_pkg.sv]
// Types and constants for the integer literal parser.
`timescale 1ns / 1ps

package ilp_pkg;

   typedef enum logic [1:0] {
      RADIX_UNDECIDED = 2'd0,
      RADIX_DEC       = 2'd1,
      RADIX_HEX       = 2'd2,
      RADIX_BIN       = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_DIGITS = 2'd1,
      STATUS_BAD_CHAR  = 2'd2
   } status_type;

   localparam logic [0:0] CSR_BIT_WIDTH   = 1'd0;
   localparam logic [0:0] CSR_SIGNED_MODE = 1'd1;

   localparam logic [4:0] BIT_WIDTH_RESET = 5'd8;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_UPPER_B = 8'h42;

   localparam logic [4:0] RADIX_VAL_DEC = 5'd10;
   localparam logic [4:0] RADIX_VAL_HEX = 5'd16;
   localparam logic [4:0] RADIX_VAL_BIN = 5'd2;

endpackage

[hdl/integer_literal_parser.sv]
// Streaming parser of ASCII integer literals (decimal, 0x hex, 0b binary).
//
// Usage: characters of a token arrive as beats on req_ (tdata = character,
// tlast = final character of the token). Each token yields one beat on rsp_
// when its final character has been processed: tdata[31:0] is the value,
// tdata[33:32] the status (ok, prefix without digits, invalid character).
// Characters accumulate as value*radix+digit, one character per cycle while
// req_tready is high; each accumulator update is a combinational shift-and-add.
// A final character passes from the input register into the token result
// register (accumulate), then through sign and width fixup into the result
// register, which presents the result beat.
// csr_ writes bit_width (index 0) and signed_mode (index 1); write only
// while the block is idle.
// Reset clears the token state and all valid flags and loads bit_width 8,
// signed_mode 0. When rsp_tready is low, the result holds, one more token
// result waits in the token result register, and req_tready drops once the
// input register holds a final character with nowhere to go.
`timescale 1ns / 1ps
`include "integer_literal_parser_defines.svh"

module integer_literal_parser #(
   parameter int ACC_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value, [33:32] status, zeros above
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [4:0]  csr_wdata
);
   import ilp_pkg::*;

   localparam int EXT_WIDTH = ((ACC_WIDTH > 32) ? ACC_WIDTH : 32) + 1;

   logic [4:0] bit_width_ff;
   logic       signed_mode_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   logic [ACC_WIDTH-1:0] acc_ff, acc_in;
   radix_type            radix_ff, radix_in;
   logic [1:0]           pos_ff, pos_in;
   logic                 lz_ff, lz_in;
   logic                 neg_ff, neg_in;
   status_type           err_ff, err_in;

   logic                 fin_valid_ff, fin_valid_in;
   logic [ACC_WIDTH-1:0] fin_acc_ff;
   logic                 fin_neg_ff;
   status_type           fin_err_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   status_type  rsp_status_ff;

   logic rsp_free, fin_free, in_go;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign fin_free   = !fin_valid_ff || rsp_free;
   assign in_go      = in_valid_ff && (!in_last_ff || fin_free);
   assign req_tready = !in_valid_ff || in_go;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_value_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_width_ff   <= BIT_WIDTH_RESET;
         signed_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BIT_WIDTH:   bit_width_ff   <= csr_wdata;
            CSR_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (in_go ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // accumulate stage
   logic                 prefix_now;
   logic                 do_digit;
   radix_type            radix_eff;
   logic [4:0]           radix_val;
   logic [4:0]           digit;
   logic                 is_digit;
   logic                 neg_step;
   logic [ACC_WIDTH-1:0] acc_scaled;
   logic [ACC_WIDTH-1:0] acc_step;
   status_type           err_step;
   status_type           err_final;

   always_comb begin
      prefix_now = 1'b0;
      do_digit   = 1'b0;
      radix_eff  = radix_ff;
      lz_in      = lz_ff;
      neg_step   = neg_ff;
      acc_step   = acc_ff;
      if (pos_ff == 2'd0) begin
         if (in_char_ff == CHAR_ZERO) begin
            lz_in    = 1'b1;
            acc_step = '0;
         end else if (in_char_ff == CHAR_MINUS) begin
            radix_eff = RADIX_DEC;
            neg_step  = 1'b1;
         end else begin
            radix_eff = RADIX_DEC;
            do_digit  = 1'b1;
         end
      end else if (radix_ff == RADIX_UNDECIDED && lz_ff) begin
         if (in_char_ff == CHAR_LOWER_X || in_char_ff == CHAR_UPPER_X) begin
            radix_eff  = RADIX_HEX;
            prefix_now = 1'b1;
         end else if (in_char_ff == CHAR_LOWER_B || in_char_ff == CHAR_UPPER_B) begin
            radix_eff  = RADIX_BIN;
            prefix_now = 1'b1;
         end else begin
            radix_eff = RADIX_DEC;
            do_digit  = 1'b1;
         end
      end else begin
         if (radix_ff == RADIX_UNDECIDED) begin
            radix_eff = RADIX_DEC;
         end
         do_digit = 1'b1;
      end

      case (radix_eff)
         RADIX_HEX: radix_val = RADIX_VAL_HEX;
         RADIX_BIN: radix_val = RADIX_VAL_BIN;
         default:   radix_val = RADIX_VAL_DEC;
      endcase

      is_digit = 1'b1;
      digit    = '0;
      if (in_char_ff inside {[CHAR_ZERO:CHAR_NINE]}) begin
         digit = 5'(in_char_ff - CHAR_ZERO);
      end else if (in_char_ff inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
         digit = 5'(in_char_ff - CHAR_LOWER_A) + 5'd10;
      end else if (in_char_ff inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         digit = 5'(in_char_ff - CHAR_UPPER_A) + 5'd10;
      end else begin
         is_digit = 1'b0;
      end
      if (digit >= radix_val) begin
         is_digit = 1'b0;
      end

      case (radix_eff)
         RADIX_HEX: acc_scaled = acc_ff << 4;
         RADIX_BIN: acc_scaled = acc_ff << 1;
         default:   acc_scaled = (acc_ff << 3) + (acc_ff << 1);
      endcase

      err_step = err_ff;
      if (do_digit) begin
         if (is_digit) begin
            acc_step = acc_scaled + ACC_WIDTH'(digit);
         end else if (err_ff == STATUS_OK) begin
            err_step = STATUS_BAD_CHAR;
         end
      end

      err_final = err_step;
      if (prefix_now && err_step == STATUS_OK) begin
         err_final = STATUS_NO_DIGITS;
      end

      acc_in   = acc_ff;
      radix_in = radix_ff;
      pos_in   = pos_ff;
      err_in   = err_ff;
      if (in_go) begin
         if (in_last_ff) begin
            acc_in   = '0;
            radix_in = RADIX_UNDECIDED;
            pos_in   = 2'd0;
            lz_in    = 1'b0;
            neg_in   = 1'b0;
            err_in   = STATUS_OK;
         end else begin
            acc_in   = acc_step;
            radix_in = radix_eff;
            pos_in   = (pos_ff == 2'd2) ? pos_ff : pos_ff + 2'd1;
            neg_in   = neg_step;
            err_in   = err_step;
         end
      end else begin
         lz_in  = lz_ff;
         neg_in = neg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         radix_ff <= RADIX_UNDECIDED;
         pos_ff   <= 2'd0;
         lz_ff    <= 1'b0;
         neg_ff   <= 1'b0;
         err_ff   <= STATUS_OK;
      end else begin
         acc_ff   <= acc_in;
         radix_ff <= radix_in;
         pos_ff   <= pos_in;
         lz_ff    <= lz_in;
         neg_ff   <= neg_in;
         err_ff   <= err_in;
      end
   end

   // token result register
   assign fin_valid_in = (in_go && in_last_ff) ? 1'b1 : (rsp_free ? 1'b0 : fin_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_go && in_last_ff) begin
         fin_acc_ff <= acc_step;
         fin_neg_ff <= neg_step;
         fin_err_ff <= err_final;
      end
   end

   // sign and width fixup stage
   logic [ACC_WIDTH-1:0] fix_mag;
   logic [EXT_WIDTH-1:0] fix_ext;
   logic [EXT_WIDTH-1:0] fix_hi_mask;
   logic [EXT_WIDTH-1:0] fix_span;
   logic [EXT_WIDTH-1:0] fix_res;
   logic [4:0]           fix_width;

   always_comb begin
      fix_mag     = fin_neg_ff ? (ACC_WIDTH'(0) - fin_acc_ff) : fin_acc_ff;
      fix_ext     = EXT_WIDTH'($signed(fix_mag));
      fix_width   = (bit_width_ff == 5'd0) ? 5'd1 : bit_width_ff;
      fix_hi_mask = {EXT_WIDTH{1'b1}} << (fix_width - 5'd1);
      fix_span    = EXT_WIDTH'(1) << fix_width;
      fix_res     = fix_ext;
      if (signed_mode_ff && !fix_ext[EXT_WIDTH-1] && |(fix_ext & fix_hi_mask)) begin
         fix_res = fix_ext - fix_span;
      end
      rsp_value_in = (fin_err_ff == STATUS_OK) ? fix_res[31:0] : 32'd0;
   end

   assign rsp_valid_in = (fin_valid_ff && rsp_free) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid_ff && rsp_free) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= fin_err_ff;
      end
   end

   `ILP_ASSERT(a_err_zero_value, clock, reset,
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_value_ff == 32'd0))
   `ILP_ASSERT_NEXT(a_fin_holds, clock, reset,
      fin_valid_ff && !rsp_free, fin_valid_ff)
   `ILP_ASSERT(a_blocked_not_ready, clock, reset,
      (in_valid_ff && !in_go) |-> !req_tready)

endmodule
